@@ design/pot_pkg.sv @@
// Shared types, constants and saturation helpers for the perceptron trainer.
`timescale 1ns / 1ps
`default_nettype none
package pot_pkg;

	localparam int FEATURE_COUNT = 16;
	localparam int POS_W         = $clog2(FEATURE_COUNT + 1);
	localparam int IDX_W         = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int FEAT_W        = 16;
	localparam int WEIGHT_W      = 32;
	localparam int RATE_W        = 24;
	localparam int SCORE_W       = 48;
	localparam int COUNT_W       = 32;
	localparam int WIDX_W        = 8;
	localparam int FRAC_SHIFT    = 8;
	localparam int MUL_A_W       = WEIGHT_W + 1;
	localparam int PROD_W        = MUL_A_W + FEAT_W;
	localparam int TERM_W        = PROD_W - FRAC_SHIFT;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

	typedef enum logic [1:0] {
		OP_TRAIN    = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SCORE,
		ST_URD,
		ST_UMUL,
		ST_UWR,
		ST_BIAS,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic use_rate;
	} mul_ctl_t;

	function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SCORE_W:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v[SCORE_W] != v[SCORE_W-1]) begin
			r = v[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic signed [WEIGHT_W:0] v);
		logic signed [WEIGHT_W-1:0] r;
		if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
			r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
		end else begin
			r = v[WEIGHT_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/pot_ifs.sv @@
// Handshake channels: sample items, results and learning rate writes.
`timescale 1ns / 1ps
`default_nettype none
interface pot_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic signed [15:0] feature;
	logic        label;
	logic        last_element;
	logic [7:0]  weight_index;

	modport source (output valid, operation, feature, label, last_element, weight_index,
		input ready);
	modport sink (input valid, operation, feature, label, last_element, weight_index,
		output ready);
endinterface

interface pot_result_if;
	logic        valid;
	logic        ready;
	logic signed [47:0] score;
	logic        mistake;
	logic        predicted_class;
	logic [31:0] update_total;
	logic signed [31:0] weight_value;

	modport source (output valid, score, mistake, predicted_class, update_total, weight_value,
		input ready);
	modport sink (input valid, score, mistake, predicted_class, update_total, weight_value,
		output ready);
endinterface

interface pot_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] learning_rate;

	modport source (output valid, learning_rate, input ready);
	modport sink (input valid, learning_rate, output ready);
endinterface
`default_nettype wire

@@ design/pot_mul.sv @@
// Shared signed multiplier with registered product for scoring and weight steps.
`timescale 1ns / 1ps
`default_nettype none
module pot_mul (
	input  wire logic                                  clk,
	input  wire pot_pkg::mul_ctl_t                     ctl,
	input  wire logic signed [pot_pkg::WEIGHT_W-1:0]   weight,
	input  wire logic [pot_pkg::RATE_W-1:0]            rate,
	input  wire logic signed [pot_pkg::FEAT_W-1:0]     operand,
	output logic signed [pot_pkg::PROD_W-1:0]          product
);

	logic signed [pot_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pot_pkg::PROD_W-1:0]  product_q;

	always_comb begin
		if (ctl.use_rate) begin
			mul_a = signed'({{(pot_pkg::MUL_A_W - pot_pkg::RATE_W){1'b0}}, rate});
		end else begin
			mul_a = pot_pkg::MUL_A_W'(weight);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			product_q <= pot_pkg::PROD_W'(mul_a) * pot_pkg::PROD_W'(operand);
		end
	end

	assign product = product_q;

endmodule
`default_nettype wire

@@ design/perceptron_online_trainer_top.sv @@
// Online perceptron trainer: sequencer, weight and sample stores, result register.
// An element below the feature count is accepted, multiplied, then accumulated.
// A last element adds a scoring step and a result step; a mistake adds a read, a multiply
// and a write step per buffered element plus a bias step. One element at a time through
// the shared multiplier. Reset zeroes the model and the sample in progress
// and sets the learning rate to 1.0; the weight store is cleared through its valid bits.
`timescale 1ns / 1ps
`default_nettype none
module perceptron_online_trainer_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pot_item_if.sink    items,
	pot_result_if.source results,
	pot_cfg_if.sink     rate_cfg
);

	localparam int FC = pot_pkg::FEATURE_COUNT;

	pot_pkg::state_t state_q, state_d;

	logic [pot_pkg::RATE_W-1:0]          rate_q;
	logic signed [pot_pkg::WEIGHT_W-1:0] bias_q;
	logic [pot_pkg::COUNT_W-1:0]         count_q;
	logic [pot_pkg::POS_W-1:0]           pos_q;
	logic signed [pot_pkg::SCORE_W-1:0]  sum_q;
	logic [pot_pkg::POS_W-1:0]           j_q;
	logic [pot_pkg::POS_W-1:0]           n_q;

	pot_pkg::op_t                        op_q;
	logic signed [pot_pkg::FEAT_W-1:0]   feat_q;
	logic                                label_q;
	logic                                last_q;
	logic [pot_pkg::WIDX_W-1:0]          widx_q;

	logic [pot_pkg::WEIGHT_W-1:0]        weight_mem [FC];
	logic [FC-1:0]                       wvalid_q;
	logic [pot_pkg::WEIGHT_W-1:0]        w_rdata_q;
	logic                                wv_rd_q;
	logic [pot_pkg::FEAT_W-1:0]          sample_mem [FC];
	logic signed [pot_pkg::FEAT_W-1:0]   s_rdata_q;

	logic signed [pot_pkg::SCORE_W-1:0]  score_q;
	logic                                mistake_q;

	logic                                out_valid_q;
	logic signed [pot_pkg::SCORE_W-1:0]  out_score_q;
	logic                                out_mistake_q;
	logic                                out_class_q;
	logic [pot_pkg::COUNT_W-1:0]         out_total_q;
	logic signed [pot_pkg::WEIGHT_W-1:0] out_weight_q;

	pot_pkg::op_t                        in_op;
	logic                                item_xfer;
	logic                                cfg_xfer;
	logic                                pos_room;
	logic                                elem_op;
	logic                                out_free;
	logic                                load_out;
	logic                                in_ready;
	logic                                w_rd_en;
	logic [pot_pkg::IDX_W-1:0]           w_rd_addr;
	logic                                s_wr_en;
	pot_pkg::mul_ctl_t                   mul_ctl;
	logic signed [pot_pkg::FEAT_W-1:0]   mul_operand;
	logic signed [pot_pkg::PROD_W-1:0]   product;

	logic signed [pot_pkg::WEIGHT_W-1:0] w_rd;
	logic signed [pot_pkg::TERM_W-1:0]   term;
	logic signed [pot_pkg::WEIGHT_W-1:0] step;
	logic signed [pot_pkg::SCORE_W:0]    sum_wide;
	logic signed [pot_pkg::SCORE_W:0]    score_wide;
	logic signed [pot_pkg::SCORE_W-1:0]  score_c;
	logic                                mistake_c;
	logic signed [pot_pkg::WEIGHT_W:0]   w_new_wide;
	logic signed [pot_pkg::RATE_W:0]     rate_s;
	logic signed [pot_pkg::WEIGHT_W:0]   bias_wide;
	logic                                widx_in_range;

	assign in_op     = pot_pkg::op_t'(items.operation);
	assign item_xfer = items.valid && in_ready;
	assign cfg_xfer  = rate_cfg.valid && rate_cfg.ready;
	assign pos_room  = pos_q < pot_pkg::POS_W'(FC);
	assign elem_op   = (in_op == pot_pkg::OP_TRAIN) || (in_op == pot_pkg::OP_CLASSIFY);
	assign out_free  = !out_valid_q || results.ready;

	assign items.ready    = in_ready;
	assign rate_cfg.ready = 1'b1;

	assign w_rd       = wv_rd_q ? signed'(w_rdata_q) : '0;
	assign term       = product[pot_pkg::PROD_W-1:pot_pkg::FRAC_SHIFT];
	assign step       = product[pot_pkg::RATE_W+pot_pkg::FEAT_W-1:pot_pkg::FRAC_SHIFT];
	assign sum_wide   = (pot_pkg::SCORE_W+1)'(sum_q) + (pot_pkg::SCORE_W+1)'(term);
	assign score_wide = (pot_pkg::SCORE_W+1)'(sum_q) + (pot_pkg::SCORE_W+1)'(bias_q);
	assign score_c    = pot_pkg::sat_score(score_wide);
	assign mistake_c  = (op_q == pot_pkg::OP_TRAIN) &&
		(label_q ? (score_c[pot_pkg::SCORE_W-1] || (score_c == '0)) : !score_c[pot_pkg::SCORE_W-1]);
	assign w_new_wide = label_q ?
		(pot_pkg::WEIGHT_W+1)'(w_rd) + (pot_pkg::WEIGHT_W+1)'(step) :
		(pot_pkg::WEIGHT_W+1)'(w_rd) - (pot_pkg::WEIGHT_W+1)'(step);
	assign rate_s     = signed'({1'b0, rate_q});
	assign bias_wide  = label_q ?
		(pot_pkg::WEIGHT_W+1)'(bias_q) + (pot_pkg::WEIGHT_W+1)'(rate_s) :
		(pot_pkg::WEIGHT_W+1)'(bias_q) - (pot_pkg::WEIGHT_W+1)'(rate_s);
	assign widx_in_range = widx_q < pot_pkg::WIDX_W'(FC);

	pot_mul u_mul (
		.clk     (clk),
		.ctl     (mul_ctl),
		.weight  (w_rd),
		.rate    (rate_q),
		.operand (mul_operand),
		.product (product)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pot_pkg::ST_IDLE: begin
				if (item_xfer) begin
					case (in_op)
						pot_pkg::OP_CLEAR: state_d = pot_pkg::ST_IDLE;
						pot_pkg::OP_READ:  state_d = pot_pkg::ST_OUT;
						default: begin
							if (pos_room) begin
								state_d = pot_pkg::ST_MUL;
							end else if (items.last_element) begin
								state_d = pot_pkg::ST_SCORE;
							end else begin
								state_d = pot_pkg::ST_IDLE;
							end
						end
					endcase
				end
			end
			pot_pkg::ST_MUL:   state_d = pot_pkg::ST_ACC;
			pot_pkg::ST_ACC:   state_d = last_q ? pot_pkg::ST_SCORE : pot_pkg::ST_IDLE;
			pot_pkg::ST_SCORE: state_d = mistake_c ? pot_pkg::ST_URD : pot_pkg::ST_OUT;
			pot_pkg::ST_URD:   state_d = pot_pkg::ST_UMUL;
			pot_pkg::ST_UMUL:  state_d = pot_pkg::ST_UWR;
			pot_pkg::ST_UWR: begin
				state_d = ((j_q + pot_pkg::POS_W'(1)) == n_q) ? pot_pkg::ST_BIAS : pot_pkg::ST_URD;
			end
			pot_pkg::ST_BIAS:  state_d = pot_pkg::ST_OUT;
			pot_pkg::ST_OUT:   state_d = out_free ? pot_pkg::ST_IDLE : pot_pkg::ST_OUT;
			default:           state_d = pot_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == pot_pkg::ST_IDLE);
		w_rd_en          = 1'b0;
		w_rd_addr        = pos_q[pot_pkg::IDX_W-1:0];
		s_wr_en          = 1'b0;
		mul_ctl.en       = 1'b0;
		mul_ctl.use_rate = 1'b0;
		mul_operand      = feat_q;
		load_out         = 1'b0;
		case (state_q)
			pot_pkg::ST_IDLE: begin
				if (in_op == pot_pkg::OP_READ) begin
					w_rd_addr = items.weight_index[pot_pkg::IDX_W-1:0];
				end
				w_rd_en = item_xfer && ((in_op == pot_pkg::OP_READ) || (elem_op && pos_room));
				s_wr_en = item_xfer && elem_op && pos_room;
			end
			pot_pkg::ST_MUL: begin
				mul_ctl.en = 1'b1;
			end
			pot_pkg::ST_URD: begin
				w_rd_en   = 1'b1;
				w_rd_addr = j_q[pot_pkg::IDX_W-1:0];
			end
			pot_pkg::ST_UMUL: begin
				mul_ctl.en       = 1'b1;
				mul_ctl.use_rate = 1'b1;
				mul_operand      = s_rdata_q;
			end
			pot_pkg::ST_OUT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pot_pkg::ST_IDLE;
			rate_q      <= pot_pkg::RATE_RESET;
			bias_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			j_q         <= '0;
			n_q         <= '0;
			wvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer) begin
				rate_q <= rate_cfg.learning_rate;
			end
			case (state_q)
				pot_pkg::ST_IDLE: begin
					if (item_xfer && (in_op == pot_pkg::OP_CLEAR)) begin
						wvalid_q <= '0;
						bias_q   <= '0;
						count_q  <= '0;
						pos_q    <= '0;
						sum_q    <= '0;
					end
				end
				pot_pkg::ST_ACC: begin
					sum_q <= pot_pkg::sat_score(sum_wide);
					pos_q <= pos_q + pot_pkg::POS_W'(1);
				end
				pot_pkg::ST_SCORE: begin
					n_q   <= pos_q;
					pos_q <= '0;
					sum_q <= '0;
					j_q   <= '0;
				end
				pot_pkg::ST_UWR: begin
					wvalid_q[j_q[pot_pkg::IDX_W-1:0]] <= 1'b1;
					j_q <= j_q + pot_pkg::POS_W'(1);
				end
				pot_pkg::ST_BIAS: begin
					bias_q <= pot_pkg::sat_weight(bias_wide);
					if (count_q != '1) begin
						count_q <= count_q + pot_pkg::COUNT_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			op_q    <= in_op;
			feat_q  <= items.feature;
			label_q <= items.label;
			last_q  <= items.last_element;
			widx_q  <= items.weight_index;
		end
		if (w_rd_en) begin
			w_rdata_q <= weight_mem[w_rd_addr];
			wv_rd_q   <= wvalid_q[w_rd_addr];
		end
		if (state_q == pot_pkg::ST_UWR) begin
			weight_mem[j_q[pot_pkg::IDX_W-1:0]] <= pot_pkg::sat_weight(w_new_wide);
		end
		if (s_wr_en) begin
			sample_mem[pos_q[pot_pkg::IDX_W-1:0]] <= items.feature;
		end
		if (state_q == pot_pkg::ST_URD) begin
			s_rdata_q <= sample_mem[j_q[pot_pkg::IDX_W-1:0]];
		end
		if (state_q == pot_pkg::ST_SCORE) begin
			score_q   <= score_c;
			mistake_q <= mistake_c;
		end
		if (load_out) begin
			out_total_q <= count_q;
			if (op_q == pot_pkg::OP_READ) begin
				out_score_q   <= '0;
				out_mistake_q <= 1'b0;
				out_class_q   <= 1'b0;
				out_weight_q  <= widx_in_range ? w_rd : '0;
			end else begin
				out_score_q   <= score_q;
				out_mistake_q <= mistake_q;
				out_class_q   <= !score_q[pot_pkg::SCORE_W-1];
				out_weight_q  <= '0;
			end
		end
	end

	assign results.valid           = out_valid_q;
	assign results.score           = out_score_q;
	assign results.mistake         = out_mistake_q;
	assign results.predicted_class = out_class_q;
	assign results.update_total    = out_total_q;
	assign results.weight_value    = out_weight_q;

`ifndef SYNTH
	a_upd_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pot_pkg::ST_UWR) |-> (j_q < n_q))
		else $error("update index past sample length");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pot_pkg::POS_W'(FC))
		else $error("element position beyond feature count");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && (in_op == pot_pkg::OP_CLEAR)) |=>
		((count_q == '0) && (bias_q == '0) && (pos_q == '0) && (wvalid_q == '0)))
		else $error("clear did not reset the model");
	a_bias_on_mistake: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pot_pkg::ST_BIAS) |-> mistake_q)
		else $error("bias step without a mistake");
`endif

endmodule
`default_nettype wire
